// File: src/cssc_pkg.sv
// Shared types, widths and constant tables for the CORDIC sine/cosine pipeline.
package cssc_pkg;

   localparam int SAMPLE_W           = 16;
   localparam int ACC_W              = 17;
   localparam int ITER_W             = 5;
   localparam int ROM_DEPTH          = 16;
   localparam int ROM_IDX_W          = 4;
   localparam int SHIFT_MAX          = 15;
   localparam int MAX_ITERATIONS_DEF = 16;
   localparam logic [ITER_W-1:0] ITERATIONS_RESET = 5'd16;

   // atan(2^-i) in degrees * 353.35, truncated toward zero
   localparam logic signed [SAMPLE_W-1:0] ATAN_ROM [ROM_DEPTH] = '{
      16'sd15900, 16'sd9386, 16'sd4959, 16'sd2517, 16'sd1263, 16'sd632, 16'sd316, 16'sd158,
      16'sd79, 16'sd39, 16'sd19, 16'sd9, 16'sd4, 16'sd2, 16'sd1, 16'sd0
   };

   // cumulative cosine products, Q15
   localparam logic signed [SAMPLE_W-1:0] GAIN_ROM [ROM_DEPTH] = '{
      16'sd23169, 16'sd20723, 16'sd20104, 16'sd19948,
      16'sd19909, 16'sd19899, 16'sd19896, 16'sd19895,
      16'sd19894, 16'sd19893, 16'sd19892, 16'sd19891,
      16'sd19890, 16'sd19889, 16'sd19888, 16'sd19888
   };

   typedef struct packed {
      logic                       valid;
      logic [ITER_W-1:0]          n;
      logic signed [SAMPLE_W-1:0] target;
      logic signed [ACC_W-1:0]    acc;
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] y;
   } cssc_beat_type;

endpackage

// File: src/cssc_stage.sv
// One CORDIC micro-rotation with its pipeline register.
module cssc_stage #(
   parameter int STAGE = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  cssc_pkg::cssc_beat_type beat_in,
   output cssc_pkg::cssc_beat_type beat_out
);
   import cssc_pkg::*;

   localparam int SHIFT = (STAGE > SHIFT_MAX) ? SHIFT_MAX : STAGE;
   localparam logic signed [SAMPLE_W-1:0] THETA =
      (STAGE < ROM_DEPTH) ? ATAN_ROM[STAGE % ROM_DEPTH] : '0;

   cssc_beat_type              beat_in_nx;
   cssc_beat_type              beat_ff;
   logic                       valid_ff;
   logic                       active;
   logic                       up;
   logic signed [ACC_W-1:0]    target_ext;
   logic signed [ACC_W-1:0]    theta_ext;
   logic signed [SAMPLE_W-1:0] dx;
   logic signed [SAMPLE_W-1:0] dy;

   always_comb begin
      active     = int'(beat_in.n) > STAGE;
      target_ext = ACC_W'(beat_in.target);
      theta_ext  = ACC_W'(THETA);
      up         = beat_in.acc < target_ext;
      dx         = beat_in.y >>> SHIFT;
      dy         = beat_in.x >>> SHIFT;
      beat_in_nx = beat_in;
      if (active) begin
         if (up) begin
            beat_in_nx.acc = beat_in.acc + theta_ext;
            beat_in_nx.x   = beat_in.x - dx;
            beat_in_nx.y   = beat_in.y + dy;
         end else begin
            beat_in_nx.acc = beat_in.acc - theta_ext;
            beat_in_nx.x   = beat_in.x + dx;
            beat_in_nx.y   = beat_in.y - dy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= beat_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         beat_ff <= beat_in_nx;
      end
   end

   always_comb begin
      beat_out       = beat_ff;
      beat_out.valid = valid_ff;
   end

endmodule

// File: src/cordic_sine_cosine_top.sv
// Top level of the pipelined CORDIC sine/cosine unit.
//
//   channel | dir | handshake           | payload
//   req     | in  | req_tvalid/tready   | tdata[15:0] angle
//   rsp     | out | rsp_tvalid/tready   | tdata[15:0] cosine, [31:16] sine
//   csr     | in  | csr_wr_en           | csr_wr_data[4:0] iterations
//
// One beat per cycle while no result waits with rsp_tready low; one register per
// micro-rotation stage. Reset clears the stage valid bits and sets iterations to 16.
// When a result waits with rsp_tready low, the whole pipe holds and req_tready drops.
module cordic_sine_cosine_top #(
   parameter int MAX_ITERATIONS = cssc_pkg::MAX_ITERATIONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [15:0] cosine, [31:16] sine
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data   // [4:0] iterations
);
   import cssc_pkg::*;

   logic [ITER_W-1:0]    iterations_ff;
   logic [ITER_W-1:0]    n_eff;
   logic [ROM_IDX_W-1:0] gain_idx;
   logic                 advance;
   cssc_beat_type        pipe [MAX_ITERATIONS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         iterations_ff <= ITERATIONS_RESET;
      end else if (csr_wr_en) begin
         iterations_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (int'(iterations_ff) > MAX_ITERATIONS) begin
         n_eff = ITER_W'(MAX_ITERATIONS);
      end else if (iterations_ff == '0) begin
         n_eff = ITER_W'(1);
      end else begin
         n_eff = iterations_ff;
      end
      if (int'(n_eff) > ROM_DEPTH) begin
         gain_idx = ROM_IDX_W'(ROM_DEPTH - 1);
      end else begin
         gain_idx = ROM_IDX_W'(n_eff - ITER_W'(1));
      end
   end

   assign advance    = !pipe[MAX_ITERATIONS].valid || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      pipe[0].valid  = req_tvalid;
      pipe[0].n      = n_eff;
      pipe[0].target = req_tdata;
      pipe[0].acc    = '0;
      pipe[0].x      = GAIN_ROM[gain_idx];
      pipe[0].y      = '0;
   end

   for (genvar s = 0; s < MAX_ITERATIONS; s++) begin : g_stage
      cssc_stage #(
         .STAGE (s)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .beat_in  (pipe[s]),
         .beat_out (pipe[s+1])
      );
   end

   assign rsp_tvalid = pipe[MAX_ITERATIONS].valid;
   assign rsp_tdata  = {pipe[MAX_ITERATIONS].y, pipe[MAX_ITERATIONS].x};

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the CORDIC sine/cosine stream unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITER_LIMIT   = cssc_pkg::MAX_ITERATIONS_DEF;
   localparam int RANDOM_BEATS = 1300;
   localparam int DRAIN_CYCLES = 24;

   typedef struct packed {
      logic signed [15:0] sine;
      logic signed [15:0] cosine;
   } trig_pair;

   typedef struct {
      logic [4:0]  iter;
      logic [15:0] angle;
      bit          known;
      logic [15:0] cos_val;
      logic [15:0] sin_val;
   } vector_row;

   // own copies of the angle step and gain tables
   localparam int ATAN_STEP [16] = '{
      15900, 9386, 4959, 2517, 1263, 632, 316, 158, 79, 39, 19, 9, 4, 2, 1, 0
   };
   localparam int GAIN_START [16] = '{
      23169, 20723, 20104, 19948, 19909, 19899, 19896, 19895,
      19894, 19893, 19892, 19891, 19890, 19889, 19888, 19888
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [15:0] angle
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [15:0] cosine, [31:16] sine
   logic        csr_wr_en = 1'b0;
   logic [4:0]  csr_wr_data = '0;  // [4:0] iterations

   trig_pair    pending_trig[$];
   logic [4:0]  iter_setting = cssc_pkg::ITERATIONS_RESET;
   int          mismatch_count = 0;
   bit          quiet = 1'b0;
   vector_row   directed_rows[23];

   cordic_sine_cosine_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic trig_pair cordic_rotate(input logic signed [15:0] angle,
                                              input logic [4:0] iter_cfg);
      int                 n;
      int                 acc;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      trig_pair           res;
      n = iter_cfg;
      if (n > ITER_LIMIT) n = ITER_LIMIT;
      if (n == 0) n = 1;
      x = 16'(GAIN_START[(n - 1 < 16) ? n - 1 : 15]);
      y = '0;
      acc = 0;
      for (int i = 0; i < n; i++) begin
         if (acc < int'(angle)) begin
            acc += (i < 16) ? ATAN_STEP[i] : 0;
            nx = x - (y >>> ((i > 15) ? 15 : i));
            ny = y + (x >>> ((i > 15) ? 15 : i));
         end else begin
            acc -= (i < 16) ? ATAN_STEP[i] : 0;
            nx = x + (y >>> ((i > 15) ? 15 : i));
            ny = y - (x >>> ((i > 15) ? 15 : i));
         end
         x = nx;
         y = ny;
      end
      res.cosine = x;
      res.sine = y;
      return res;
   endfunction

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_angle(input logic [15:0] angle, input bit known,
                             input trig_pair known_val);
      while (!quiet && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= angle;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_trig.push_back(known ? known_val : cordic_rotate(angle, iter_setting));
      @(negedge clock);
   endtask

   task automatic set_iterations(input logic [4:0] value);
      req_tvalid <= 1'b0;
      while (pending_trig.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      iter_setting = value;
   endtask

   function automatic logic [15:0] pick_angle();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return 16'($urandom);
      if (roll < 80) return 16'($urandom_range(8)) - 16'd4;
      if (roll < 88) return 16'h7FFF - 16'($urandom_range(8));
      if (roll < 93) return 16'h8000 + 16'($urandom_range(8));
      return ($urandom_range(1) ? 16'd31800 : -16'sd31800) + 16'($urandom_range(40)) - 16'd20;
   endfunction

   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= 36);
   end

   always @(posedge clock) begin
      trig_pair want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_trig.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_trig.pop_front();
            if (rsp_tdata[15:0] !== want.cosine) begin
               $display("%0t: cosine expected %h actual %h", $time, want.cosine,
                        rsp_tdata[15:0]);
               mismatch_count++;
            end
            if (rsp_tdata[31:16] !== want.sine) begin
               $display("%0t: sine expected %h actual %h", $time, want.sine,
                        rsp_tdata[31:16]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int       sent;
      int       span;
      logic [4:0] iter_pick;
      trig_pair kv;
      directed_rows = '{
         '{5'd16, 16'd0,       1'b0, 16'h0, 16'h0},
         '{5'd16, 16'h7FFF,    1'b0, 16'h0, 16'h0},
         '{5'd16, 16'h8000,    1'b0, 16'h0, 16'h0},
         '{5'd16, 16'd1,       1'b0, 16'h0, 16'h0},
         '{5'd16, 16'hFFFF,    1'b0, 16'h0, 16'h0},
         '{5'd16, 16'd15900,   1'b0, 16'h0, 16'h0},
         '{5'd16, -16'sd15900, 1'b0, 16'h0, 16'h0},
         '{5'd16, 16'd31800,   1'b0, 16'h0, 16'h0},
         '{5'd16, -16'sd31800, 1'b0, 16'h0, 16'h0},
         '{5'd16, 16'd7950,    1'b0, 16'h0, 16'h0},
         '{5'd1,  16'd0,       1'b1, 16'h5A81, 16'hA57F},
         '{5'd1,  16'd1,       1'b1, 16'h5A81, 16'h5A81},
         '{5'd1,  16'h7FFF,    1'b1, 16'h5A81, 16'h5A81},
         '{5'd1,  16'h8000,    1'b1, 16'h5A81, 16'hA57F},
         '{5'd0,  16'd0,       1'b1, 16'h5A81, 16'hA57F},
         '{5'd0,  16'h7FFF,    1'b1, 16'h5A81, 16'h5A81},
         '{5'd31, 16'd0,       1'b0, 16'h0, 16'h0},
         '{5'd31, 16'd31800,   1'b0, 16'h0, 16'h0},
         '{5'd31, 16'h8000,    1'b0, 16'h0, 16'h0},
         '{5'd17, 16'd15900,   1'b0, 16'h0, 16'h0},
         '{5'd17, -16'sd7950,  1'b0, 16'h0, 16'h0},
         '{5'd2,  16'd1000,    1'b0, 16'h0, 16'h0},
         '{5'd2,  -16'sd1000,  1'b0, 16'h0, 16'h0}
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].iter != iter_setting) set_iterations(directed_rows[r].iter);
         kv.cosine = directed_rows[r].cos_val;
         kv.sine = directed_rows[r].sin_val;
         send_angle(directed_rows[r].angle, directed_rows[r].known, kv);
      end

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         case ($urandom_range(5))
            0: iter_pick = 5'd0;
            1: iter_pick = 5'd1;
            2: iter_pick = 5'd16;
            3: iter_pick = 5'd31;
            default: iter_pick = 5'($urandom_range(31));
         endcase
         set_iterations(iter_pick);
         span = $urandom_range(40, 160);
         for (int k = 0; k < span && sent < RANDOM_BEATS; k++) begin
            quiet = (sent >= 500 && sent < 700);
            send_angle(pick_angle(), 1'b0, kv);
            sent++;
         end
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      while (pending_trig.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
